[rtl/rlwq_pkg.sv]
package rlwq_pkg;

    localparam int WAIT_DEPTH = 16;
    localparam int ID_BITS    = 16;
    localparam int COUNT_BITS = 8;
    localparam int FILL_BITS  = $clog2(WAIT_DEPTH + 1);

    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [FILL_BITS-1:0]  t_fill;

    localparam t_count COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOCK    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_ADD     = 2'd2,
        OP_REMOVE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL_ID   = 3'd1,
        ST_BUSY      = 3'd2,
        ST_FULL      = 3'd3,
        ST_SATURATED = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    // control broadcast to every list cell
    typedef struct packed {
        logic  en;
        logic  shift;
        logic  append;
        t_id   id;
        t_fill fill;
        t_fill wr_pos;
    } t_cell_ctl;

endpackage

[rtl/rlwq_if.sv]
interface rlwq_req_if;
    import rlwq_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    t_id        requester_id;

    modport source (output valid, output opcode, output requester_id, input ready);
    modport sink   (input valid, input opcode, input requester_id, output ready);
endinterface

interface rlwq_rsp_if;
    import rlwq_pkg::*;
    logic       valid;
    logic       ready;
    logic       success;
    logic [2:0] status;
    logic       lock_free;
    logic       requester_is_owner;
    t_id        owner_id;
    t_count     hold_count;
    t_id        head_waiter;
    t_fill      waiter_total;

    modport source (output valid, output success, output status, output lock_free,
                    output requester_is_owner, output owner_id, output hold_count,
                    output head_waiter, output waiter_total, input ready);
    modport sink   (input valid, input success, input status, input lock_free,
                    input requester_is_owner, input owner_id, input hold_count,
                    input head_waiter, input waiter_total, output ready);
endinterface

[rtl/rlwq_cell.sv]
module rlwq_cell (
    input  logic                i_clk,
    input  rlwq_pkg::t_cell_ctl i_ctl,
    input  rlwq_pkg::t_fill     i_index,
    input  logic                i_found,
    input  rlwq_pkg::t_id       i_right,
    output logic                o_found,
    output rlwq_pkg::t_id       o_slot,
    output rlwq_pkg::t_id       o_next
);
    import rlwq_pkg::*;

    t_id  r_slot;
    t_id  n_slot;
    logic w_match;

    assign w_match = (i_index < i_ctl.fill) && (r_slot == i_ctl.id);
    // a match here or to the left means this cell closes the gap
    assign o_found = i_found | w_match;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.append && (i_ctl.wr_pos == i_index)) begin
            n_slot = i_ctl.id;
        end else if (i_ctl.shift && o_found) begin
            n_slot = i_right;
        end
    end

    assign o_slot = r_slot;
    assign o_next = n_slot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_slot <= n_slot;
        end
    end

endmodule

[rtl/recursive_lock_with_wait_queue_core.sv]
// Channel   Dir  Fields
// i_req     in   opcode[1:0], requester_id[15:0]
// o_rsp     out  success, status[2:0], lock_free, requester_is_owner, owner_id[15:0],
//                hold_count[7:0], head_waiter[15:0], waiter_total[4:0]
//
// One request per cycle unless o_rsp stalls; the response follows in the next cycle.
// The waiter list is a row of 16 cells; the match search ripples through the row
// in the same cycle, so the row sets the critical path.
// Reset (synchronous, i_rst_n low) frees the lock and empties the list.
// A stalled response blocks new requests only while the output register is full
// and o_rsp.ready is low.
module recursive_lock_with_wait_queue_core (
    input  logic i_clk,
    input  logic i_rst_n,
    rlwq_req_if.sink   i_req,
    rlwq_rsp_if.source o_rsp
);
    import rlwq_pkg::*;

    typedef struct packed {
        logic    success;
        t_status status;
        logic    lock_free;
        logic    is_owner;
        t_id     owner;
        t_count  hold;
        t_id     head;
        t_fill   fill;
    } t_result;

    t_id       r_owner, n_owner;
    t_count    r_hold, n_hold;
    t_fill     r_fill, n_fill;
    logic      r_valid;
    t_result   r_out, n_out;
    t_cell_ctl w_ctl;
    logic      w_accept;
    t_op       w_op;
    t_id       w_id;
    logic      w_found [0:WAIT_DEPTH];
    t_id       w_slot  [0:WAIT_DEPTH-1];
    t_id       w_next  [0:WAIT_DEPTH-1];

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_op        = t_op'(i_req.opcode);
    assign w_id        = i_req.requester_id;
    assign w_found[0]  = 1'b0;

    for (genvar k = 0; k < WAIT_DEPTH; k++) begin : g_cell
        rlwq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (t_fill'(k)),
            .i_found (w_found[k]),
            .i_right (w_slot[(k + 1 < WAIT_DEPTH) ? k + 1 : k]),
            .o_found (w_found[k+1]),
            .o_slot  (w_slot[k]),
            .o_next  (w_next[k])
        );
    end

    // On a shift each cell at or right of the match takes its right neighbor's current
    // slot; the head comes from the next value of the first cell.
    always_comb begin
        n_owner       = r_owner;
        n_hold        = r_hold;
        n_fill        = r_fill;
        n_out.success = 1'b0;
        n_out.status  = ST_OK;
        w_ctl.en      = w_accept;
        w_ctl.shift   = 1'b0;
        w_ctl.append  = 1'b0;
        w_ctl.id      = w_id;
        w_ctl.fill    = r_fill;
        w_ctl.wr_pos  = r_fill;

        if (w_id == '0) begin
            n_out.status = ST_NULL_ID;
        end else begin
            unique case (w_op)
                OP_LOCK: begin
                    if (r_hold == '0) begin
                        n_owner       = w_id;
                        n_hold        = t_count'(1);
                        n_out.success = 1'b1;
                    end else if (r_owner == w_id) begin
                        if (r_hold == COUNT_MAX) begin
                            n_out.status = ST_SATURATED;
                        end else begin
                            n_hold        = r_hold + t_count'(1);
                            n_out.success = 1'b1;
                        end
                    end else begin
                        n_out.status = ST_BUSY;
                    end
                end
                OP_RELEASE: begin
                    if (r_owner != w_id || r_hold == '0) begin
                        n_out.status = ST_BUSY;
                    end else begin
                        n_hold        = r_hold - t_count'(1);
                        n_owner       = (n_hold == '0) ? '0 : r_owner;
                        n_out.success = 1'b1;
                    end
                end
                OP_ADD: begin
                    w_ctl.shift = 1'b1;
                    if (w_found[WAIT_DEPTH]) begin
                        // drop the old copy, requeue at the tail
                        w_ctl.append  = 1'b1;
                        w_ctl.wr_pos  = r_fill - t_fill'(1);
                        n_out.success = 1'b1;
                    end else if (r_fill >= t_fill'(WAIT_DEPTH)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        w_ctl.append  = 1'b1;
                        n_fill        = r_fill + t_fill'(1);
                        n_out.success = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    w_ctl.shift = 1'b1;
                    if (w_found[WAIT_DEPTH]) begin
                        n_fill        = r_fill - t_fill'(1);
                        n_out.success = 1'b1;
                    end else begin
                        n_out.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    n_out.status = ST_OK;
                end
            endcase
        end

        n_out.lock_free = (n_hold == '0);
        n_out.is_owner  = (w_id != '0) && (w_id == n_owner);
        n_out.owner     = n_owner;
        n_out.hold      = n_hold;
        n_out.head      = (n_fill != '0) ? w_next[0] : '0;
        n_out.fill      = n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
            r_hold  <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_owner <= n_owner;
                r_hold  <= n_hold;
                r_fill  <= n_fill;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid              = r_valid;
    assign o_rsp.success            = r_out.success;
    assign o_rsp.status             = r_out.status;
    assign o_rsp.lock_free          = r_out.lock_free;
    assign o_rsp.requester_is_owner = r_out.is_owner;
    assign o_rsp.owner_id           = r_out.owner;
    assign o_rsp.hold_count         = r_out.hold;
    assign o_rsp.head_waiter        = r_out.head;
    assign o_rsp.waiter_total       = r_out.fill;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_fill'(WAIT_DEPTH))
        else $error("waiter count beyond list depth");

    a_owner_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold == '0) == (r_owner == '0))
        else $error("owner and hold count disagree");

    a_success_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.success == (o_rsp.status == ST_OK)))
        else $error("success flag and status disagree");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> ($stable(r_fill) && $stable(r_hold)))
        else $error("state moved while response stalled");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + t_fill'(1))
                      || (r_fill == $past(r_fill) - t_fill'(1))))
        else $error("waiter count changed by more than one");

endmodule

[dv/tb_recursive_lock_with_wait_queue_core.sv]
module tb_recursive_lock_with_wait_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rlwq_pkg::*;

    typedef struct packed {
        t_op op;
        t_id id;
    } lock_req_t;

    typedef struct packed {
        logic    success;
        t_status status;
        logic    lock_free;
        logic    is_owner;
        t_id     owner;
        t_count  hold;
        t_id     head;
        t_fill   total;
    } lock_reply_t;

    logic i_clk;
    logic i_rst_n;

    rlwq_req_if req_if ();
    rlwq_rsp_if rsp_if ();

    recursive_lock_with_wait_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    lock_req_t   pending_requests[$];
    lock_reply_t expected_replies[$];

    // shadow of the lock and waiter list
    t_id    shadow_owner;
    t_count shadow_depth;
    t_id    shadow_waiters[$];

    t_id waiter_pool[20];
    t_id lock_pool[4];

    int err_count;
    int req_gap;
    int rsp_stall;
    int stall_draw;
    bit req_calm;
    bit rsp_calm;

    function automatic lock_reply_t apply_lock_request(input t_op op, input t_id id);
        lock_reply_t r;
        int          pos;
        r = '0;
        r.status = ST_OK;
        pos = -1;
        foreach (shadow_waiters[k])
            if (pos < 0 && shadow_waiters[k] == id) pos = k;

        if (id == '0) begin
            r.status = ST_NULL_ID;
        end else begin
            case (op)
                OP_LOCK: begin
                    if (shadow_depth == '0) begin
                        shadow_owner = id;
                        shadow_depth = t_count'(1);
                        r.success = 1'b1;
                    end else if (shadow_owner == id) begin
                        if (shadow_depth == COUNT_MAX) begin
                            r.status = ST_SATURATED;
                        end else begin
                            shadow_depth++;
                            r.success = 1'b1;
                        end
                    end else begin
                        r.status = ST_BUSY;
                    end
                end
                OP_RELEASE: begin
                    if (shadow_owner != id || shadow_depth == '0) begin
                        r.status = ST_BUSY;
                    end else begin
                        shadow_depth--;
                        if (shadow_depth == '0) shadow_owner = '0;
                        r.success = 1'b1;
                    end
                end
                OP_ADD: begin
                    if (pos >= 0) begin
                        // move an already listed ID to the tail
                        shadow_waiters.delete(pos);
                        shadow_waiters.insert(shadow_waiters.size(), id);
                        r.success = 1'b1;
                    end else if (shadow_waiters.size() >= WAIT_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        shadow_waiters.insert(shadow_waiters.size(), id);
                        r.success = 1'b1;
                    end
                end
                default: begin
                    if (pos >= 0) begin
                        shadow_waiters.delete(pos);
                        r.success = 1'b1;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
            endcase
        end

        r.lock_free = (shadow_depth == '0);
        r.is_owner  = (id != '0 && id == shadow_owner);
        r.owner     = shadow_owner;
        r.hold      = shadow_depth;
        r.head      = (shadow_waiters.size() > 0) ? shadow_waiters[0] : '0;
        r.total     = t_fill'(shadow_waiters.size());
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_reply(input lock_reply_t want);
        compare_field("success", want.success, rsp_if.success);
        compare_field("status", want.status, rsp_if.status);
        compare_field("lock_free", want.lock_free, rsp_if.lock_free);
        compare_field("requester_is_owner", want.is_owner, rsp_if.requester_is_owner);
        compare_field("owner_id", want.owner, rsp_if.owner_id);
        compare_field("hold_count", want.hold, rsp_if.hold_count);
        compare_field("head_waiter", want.head, rsp_if.head_waiter);
        compare_field("waiter_total", want.total, rsp_if.waiter_total);
    endtask

    task automatic queue_req(input t_op op, input t_id id);
        lock_req_t q;
        q.op = op;
        q.id = id;
        pending_requests.insert(pending_requests.size(), q);
    endtask

    // random op; lock and add ids come from the pools so the lock and list never clog
    task automatic queue_noise();
        t_op op;
        t_id id;
        int  r;
        op = t_op'($urandom_range(0, 3));
        r = $urandom_range(0, 7);
        if (r == 0)
            id = '0;
        else if (op == OP_LOCK)
            id = lock_pool[$urandom_range(0, 3)];
        else if (r <= 3 || op == OP_ADD)
            id = waiter_pool[$urandom_range(0, 19)];
        else
            id = t_id'($urandom_range(1, 16'hFFFF));
        queue_req(op, id);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.opcode <= OP_LOCK;
            req_if.requester_id <= '0;
            req_gap <= 0;
        end else if (req_if.valid && !req_if.ready) begin
            // hold the item until the transfer
        end else begin
            if (req_if.valid)
                expected_replies.insert(expected_replies.size(),
                    apply_lock_request(t_op'(req_if.opcode), req_if.requester_id));
            if (req_gap != 0) begin
                req_if.valid <= 1'b0;
                req_gap <= req_gap - 1;
            end else if (pending_requests.size() != 0) begin
                req_if.valid <= 1'b1;
                req_if.opcode <= pending_requests[0].op;
                req_if.requester_id <= pending_requests[0].id;
                void'(pending_requests.pop_front());
                if ($urandom_range(0, 29) == 0) req_calm = !req_calm;
                req_gap <= req_calm ? 0 : $urandom_range(0, 11);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_stall <= 0;
        end else if (rsp_if.valid && rsp_if.ready) begin
            if (expected_replies.size() == 0) begin
                $error("response with nothing expected");
                err_count++;
            end else begin
                check_reply(expected_replies.pop_front());
            end
            if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
            stall_draw = rsp_calm ? 0 : $urandom_range(0, 11);
            rsp_if.ready <= (stall_draw == 0);
            rsp_stall <= stall_draw;
        end else if (!rsp_if.ready) begin
            rsp_if.ready <= (rsp_stall <= 1);
            rsp_stall <= (rsp_stall <= 1) ? 0 : rsp_stall - 1;
        end
    end

    initial begin : stimulus
        t_id sat_id;
        int  n;
        int  kind;
        int  len;
        int  r;
        int  add_weight;

        err_count = 0;
        req_calm = 1'b0;
        rsp_calm = 1'b0;
        shadow_owner = '0;
        shadow_depth = '0;
        req_if.valid = 1'b0;
        req_if.opcode = OP_LOCK;
        req_if.requester_id = '0;
        rsp_if.ready = 1'b0;
        i_rst_n = 1'b0;

        foreach (waiter_pool[k]) waiter_pool[k] = t_id'($urandom_range(1, 16'hFFFF));
        foreach (lock_pool[k]) lock_pool[k] = waiter_pool[$urandom_range(0, 19)];

        // null requester on every operation
        queue_req(OP_LOCK, 16'h0000);
        queue_req(OP_RELEASE, 16'h0000);
        queue_req(OP_ADD, 16'h0000);
        queue_req(OP_REMOVE, 16'h0000);
        // release of a free lock, remove from an empty list
        queue_req(OP_RELEASE, 16'h0001);
        queue_req(OP_REMOVE, 16'hFFFF);
        // take, re-enter, foreign take, foreign release
        queue_req(OP_LOCK, 16'hFFFF);
        queue_req(OP_LOCK, 16'hFFFF);
        queue_req(OP_LOCK, 16'h0001);
        queue_req(OP_RELEASE, 16'h0001);
        // re-adding a listed ID moves it to the tail
        queue_req(OP_ADD, 16'h0001);
        queue_req(OP_ADD, 16'hFFFF);
        queue_req(OP_ADD, 16'h5A5A);
        queue_req(OP_ADD, 16'h0001);
        queue_req(OP_REMOVE, 16'h5A5A);
        queue_req(OP_REMOVE, 16'h1234);
        queue_req(OP_RELEASE, 16'hFFFF);
        queue_req(OP_RELEASE, 16'hFFFF);
        queue_req(OP_REMOVE, 16'hFFFF);
        queue_req(OP_REMOVE, 16'h0001);

        // drive the hold count past saturation, then unwind it
        sat_id = t_id'($urandom_range(1, 16'hFFFF));
        queue_req(OP_LOCK, sat_id);
        n = 1;
        while (n < 262) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_noise();
            end else begin
                queue_req(OP_LOCK, sat_id);
                n++;
            end
        end
        n = 0;
        while (n < 258) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_noise();
            end else begin
                queue_req(OP_RELEASE, sat_id);
                n++;
            end
        end

        while (pending_requests.size() < 1350) begin
            kind = $urandom_range(0, 2);
            len = $urandom_range(20, 80);
            add_weight = $urandom_range(50, 85);
            repeat (len) begin
                r = $urandom_range(0, 99);
                case (kind)
                    0: begin
                        if (r < 45)
                            queue_req(OP_LOCK, lock_pool[$urandom_range(0, 3)]);
                        else if (r < 85)
                            queue_req(OP_RELEASE, lock_pool[$urandom_range(0, 3)]);
                        else
                            queue_noise();
                    end
                    1: begin
                        if (r < add_weight)
                            queue_req(OP_ADD, waiter_pool[$urandom_range(0, 19)]);
                        else if (r < 95)
                            queue_req(OP_REMOVE, waiter_pool[$urandom_range(0, 19)]);
                        else
                            queue_noise();
                    end
                    default: queue_noise();
                endcase
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_if.valid
               || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
